// File: src/process_table_lifecycle_engine_defines.svh
// assertion helpers shared by the engine modules
`ifndef PROCESS_TABLE_LIFECYCLE_ENGINE_DEFINES_SVH
`define PROCESS_TABLE_LIFECYCLE_ENGINE_DEFINES_SVH

// property checked on every clock edge outside reset
`define PTLE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define PTLE_ASSERT_NEXT(name, cond, conseq, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// File: src/ptle_pkg.sv
`default_nettype none
package ptle_pkg;

	// table geometry
	localparam int SLOTS   = 64;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int LADDR_W = 2 * SLOT_W;

	// stream widths
	localparam int IN_W  = 40;
	localparam int OUT_W = 168;

	// operation codes
	localparam logic [2:0] OP_FORK    = 3'd0;
	localparam logic [2:0] OP_EXIT    = 3'd1;
	localparam logic [2:0] OP_WAIT    = 3'd2;
	localparam logic [2:0] OP_KILLALL = 3'd3;
	localparam logic [2:0] OP_SIGNAL  = 3'd4;
	localparam logic [2:0] OP_NICE    = 3'd5;

	// life states
	localparam logic [2:0] LIFE_RUN  = 3'd0;
	localparam logic [2:0] LIFE_BLK  = 3'd1;
	localparam logic [2:0] LIFE_STOP = 3'd2;
	localparam logic [2:0] LIFE_ZOMB = 3'd3;
	localparam logic [2:0] LIFE_TERM = 3'd4;

	// outcome codes
	localparam logic [2:0] OUT_DONE    = 3'd0;
	localparam logic [2:0] OUT_NONE    = 3'd1;
	localparam logic [2:0] OUT_BLOCKED = 3'd2;
	localparam logic [2:0] OUT_FULL    = 3'd3;
	localparam logic [2:0] OUT_NOPID   = 3'd4;

	// signal numbers and limits
	localparam logic [15:0] SIG_TERM  = 16'd15;
	localparam logic [15:0] SIG_CONT  = 16'd18;
	localparam logic [15:0] SIG_STOP  = 16'd19;
	localparam logic [15:0] INIT_PID  = 16'd1;
	localparam logic [15:0] ANY_CHILD = 16'hFFFF;
	localparam logic [1:0]  PRI_MAX   = 2'd3;
	localparam logic [6:0]  ACT_MAX   = 7'd127;

	typedef struct packed {
		logic [15:0]      pid;
		logic [2:0]       life;
		logic [1:0]       pri;
		logic [31:0]      ticks;
		logic [CNT_W-1:0] cnt;
	} slot_t;

	typedef struct packed {
		logic [15:0]       pid;
		logic [SLOT_W-1:0] idx;
	} lent_t;

	// datapath micro-operations
	typedef enum logic [4:0] {
		MO_IDLE, MO_LOAD, MO_SCAN, MO_DISP, MO_FORK, MO_EXIT, MO_SIG, MO_NICE,
		MO_WBT, MO_LRD, MO_CRD, MO_CHK, MO_IRD, MO_IADD, MO_KILL, MO_NEXT,
		MO_REAP, MO_LLAST, MO_LMOVE, MO_WFIN, MO_OUT
	} mo_t;

	typedef struct packed {
		logic [2:0] op;
		logic       tfound;
		logic       ffound;
		logic       nopid;
		logic       t_zombie;
		logic       tidx_zero;
		logic       scan_last;
		logic       loop_end;
		logic       c_live;
		logic       c_zombie;
		logic       c_match;
		logic       out_free;
	} dp_status_t;

	function automatic logic [31:0] sat32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// contents of a slot never written since reset
	function automatic slot_t slot_default(input logic is_init);
		slot_t r;
		r.pid   = is_init ? INIT_PID : 16'd0;
		r.life  = is_init ? LIFE_RUN : LIFE_TERM;
		r.pri   = is_init ? 2'd0 : 2'd1;
		r.ticks = 32'd0;
		r.cnt   = '0;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/process_table_lifecycle_engine.sv
// Process table engine: keeps SLOTS process entries and applies one fork, exit, wait,
// killall, signal or nice command per input item, answering with one result item.
// Every item first sweeps the whole slot table, one read a cycle, to find the target
// entry and the first free slot, then dispatches. Fork, signal and nice then update
// the target, write it back and present the result; an unknown code or a missing
// target goes straight to the result. Exit, killall and wait walk the target's child
// list with a list read, child slot read, check and optional update or re-parent per
// listed child, and a reap ends the walk by moving the last list entry, writing back
// and presenting the result. A finished item may wait for the previous result to be
// taken. One item is in work at a time; a finished result waits in the output
// register while the next item is taken.
`default_nettype none
module process_table_lifecycle_engine (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// operation[2:0], target_pid[18:3], argument[34:19], zero pad
	input  wire logic [39:0]  s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// outcome[2:0], pid_out[18:3], entry_found[19], entry_state[22:20],
	// entry_priority[24:23], entry_ticks[56:25], created_total[88:57],
	// peak_active[95:89], active_now[102:96], zombies_total[134:103],
	// killed_total[166:135], zero pad
	output logic [167:0]      m_axis_tdata
);
	import ptle_pkg::*;

	mo_t mo;
	dp_status_t st;

	// sequencer
	ptle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.st       (st),
		.in_ready (s_axis_tready),
		.mo       (mo)
	);

	// table, lists and counters
	ptle_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.mo        (mo),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.st        (st),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);
endmodule
`default_nettype wire

// File: src/ptle_dp.sv
`default_nettype none
module ptle_dp (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ptle_pkg::mo_t            mo,
	input  wire logic [ptle_pkg::IN_W-1:0] in_data,
	input  wire logic                     out_ready,
	output ptle_pkg::dp_status_t          st,
	output logic                          out_valid,
	output logic [ptle_pkg::OUT_W-1:0]    out_data
);
	import ptle_pkg::*;
	`include "process_table_lifecycle_engine_defines.svh"

	// slot table and child lists
	slot_t slot_mem [SLOTS];
	lent_t list_mem [SLOTS*SLOTS];
	logic [SLOTS-1:0] slot_vld_q;
	slot_t srd_q;
	logic srd_vld_q;
	logic [SLOT_W-1:0] sraddr_q;
	lent_t lrd_q;

	// operation registers
	logic [2:0] op_q;
	logic [15:0] target_q, arg_q;
	logic [CNT_W-1:0] k_q;
	logic tfound_q, ffound_q, scan_v_q, live_q;
	logic [SLOT_W-1:0] tidx_q, fidx_q;
	slot_t trec_q;
	logic [2:0] outcome_q;
	logic [15:0] pid_out_q;

	// global counters
	logic [16:0] next_pid_q;
	logic [31:0] created_q, zomb_q, killed_q;
	logic [6:0] peak_q, active_q;
	logic out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	slot_t slot_rd, child_rec, sw_data;
	lent_t lw_data;
	logic srd_en, sw_en, lw_en, lr_en;
	logic [SLOT_W-1:0] sraddr, sw_addr;
	logic [LADDR_W-1:0] lw_addr, lr_addr;
	logic [CNT_W-1:0] lastk;
	logic [6:0] act_inc;
	logic signed [17:0] nsum;
	logic c_live;

	assign slot_rd = srd_vld_q ? srd_q : slot_default(sraddr_q == '0);
	assign lastk = trec_q.cnt - CNT_W'(1);
	assign act_inc = (active_q < ACT_MAX) ? active_q + 7'd1 : active_q;
	assign nsum = $signed({16'd0, trec_q.pri}) + $signed({{2{arg_q[15]}}, arg_q});
	assign c_live = (slot_rd.pid == lrd_q.pid) && (slot_rd.life != LIFE_TERM);

	always_comb begin
		child_rec.pid   = next_pid_q[15:0];
		child_rec.life  = LIFE_RUN;
		child_rec.pri   = tfound_q ? trec_q.pri : 2'd1;
		child_rec.ticks = 32'd0;
		child_rec.cnt   = '0;
	end

	// read address selection
	always_comb begin
		srd_en = 1'b0;
		sraddr = tidx_q;
		lr_en = 1'b0;
		lr_addr = {tidx_q, k_q[SLOT_W-1:0]};
		unique case (mo)
			MO_SCAN: begin
				srd_en = 1'b1;
				sraddr = k_q[SLOT_W-1:0];
			end
			MO_CRD: begin
				srd_en = 1'b1;
				sraddr = lrd_q.idx;
			end
			MO_IRD: begin
				srd_en = 1'b1;
				sraddr = '0;
			end
			MO_LRD: lr_en = 1'b1;
			MO_LLAST: begin
				lr_en = 1'b1;
				lr_addr = {tidx_q, lastk[SLOT_W-1:0]};
			end
			default: ;
		endcase
	end

	// write port selection
	always_comb begin
		sw_en = 1'b0;
		sw_addr = tidx_q;
		sw_data = trec_q;
		lw_en = 1'b0;
		lw_addr = {tidx_q, k_q[SLOT_W-1:0]};
		lw_data = lrd_q;
		unique case (mo)
			MO_FORK: begin
				sw_en = 1'b1;
				sw_addr = fidx_q;
				sw_data = child_rec;
				lw_en = tfound_q && (trec_q.cnt < CNT_W'(SLOTS));
				lw_addr = {tidx_q, trec_q.cnt[SLOT_W-1:0]};
				lw_data.pid = next_pid_q[15:0];
				lw_data.idx = fidx_q;
			end
			MO_WBT: sw_en = tfound_q;
			MO_IADD: begin
				sw_en = slot_rd.cnt < CNT_W'(SLOTS);
				sw_addr = '0;
				sw_data = slot_rd;
				sw_data.cnt = slot_rd.cnt + CNT_W'(1);
				lw_en = slot_rd.cnt < CNT_W'(SLOTS);
				lw_addr = {{SLOT_W{1'b0}}, slot_rd.cnt[SLOT_W-1:0]};
			end
			MO_KILL: begin
				sw_en = 1'b1;
				sw_addr = lrd_q.idx;
				sw_data = slot_rd;
				sw_data.life = LIFE_ZOMB;
				sw_data.ticks = sat32(slot_rd.ticks);
			end
			MO_REAP: begin
				sw_en = 1'b1;
				sw_addr = lrd_q.idx;
				sw_data = slot_rd;
				sw_data.life = LIFE_TERM;
			end
			MO_LMOVE: lw_en = 1'b1;
			default: ;
		endcase
	end

	// table memories
	always_ff @(posedge clk) begin
		if (sw_en) slot_mem[sw_addr] <= sw_data;
		if (srd_en) srd_q <= slot_mem[sraddr];
	end

	always_ff @(posedge clk) begin
		if (lw_en) list_mem[lw_addr] <= lw_data;
		if (lr_en) lrd_q <= list_mem[lr_addr];
	end

	// written marks for the slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			srd_vld_q <= 1'b0;
			sraddr_q <= '0;
		end else begin
			if (sw_en) slot_vld_q[sw_addr] <= 1'b1;
			if (srd_en) begin
				srd_vld_q <= slot_vld_q[sraddr];
				sraddr_q <= sraddr;
			end
		end
	end

	// operation sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_FORK;
			target_q <= '0;
			arg_q <= '0;
			k_q <= '0;
			tfound_q <= 1'b0;
			ffound_q <= 1'b0;
			scan_v_q <= 1'b0;
			live_q <= 1'b0;
			tidx_q <= '0;
			fidx_q <= '0;
			trec_q <= slot_default(1'b0);
			outcome_q <= OUT_NONE;
			pid_out_q <= '0;
			next_pid_q <= 17'd2;
			created_q <= 32'd1;
			peak_q <= 7'd1;
			active_q <= 7'd1;
			zomb_q <= '0;
			killed_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			scan_v_q <= (mo == MO_SCAN);
			if (out_valid_q && out_ready && mo != MO_OUT) out_valid_q <= 1'b0;

			// lookup sweep: first free slot and the target entry
			if (scan_v_q) begin
				if (!ffound_q && slot_rd.life == LIFE_TERM) begin
					ffound_q <= 1'b1;
					fidx_q <= sraddr_q;
				end
				if (!tfound_q && slot_rd.life != LIFE_TERM && slot_rd.pid == target_q) begin
					tfound_q <= 1'b1;
					tidx_q <= sraddr_q;
					trec_q <= slot_rd;
				end
			end

			unique case (mo)
				MO_LOAD: begin
					op_q <= in_data[2:0];
					target_q <= in_data[18:3];
					arg_q <= in_data[34:19];
					outcome_q <= OUT_NONE;
					pid_out_q <= '0;
					k_q <= '0;
					tfound_q <= 1'b0;
					ffound_q <= 1'b0;
				end
				MO_SCAN: k_q <= k_q + CNT_W'(1);
				MO_DISP: begin
					k_q <= '0;
					live_q <= 1'b0;
					if (op_q == OP_FORK) begin
						if (!ffound_q) outcome_q <= OUT_FULL;
						else if (next_pid_q[16]) outcome_q <= OUT_NOPID;
					end
				end
				MO_FORK: begin
					next_pid_q <= next_pid_q + 17'd1;
					created_q <= sat32(created_q);
					active_q <= act_inc;
					peak_q <= (act_inc > peak_q) ? act_inc : peak_q;
					outcome_q <= OUT_DONE;
					pid_out_q <= next_pid_q[15:0];
					if (tfound_q) begin
						trec_q.ticks <= sat32(trec_q.ticks);
						if (trec_q.cnt < CNT_W'(SLOTS)) trec_q.cnt <= trec_q.cnt + CNT_W'(1);
					end else if (target_q == next_pid_q[15:0]) begin
						// the new child carries the pid that was asked about
						trec_q <= child_rec;
						tidx_q <= fidx_q;
						tfound_q <= 1'b1;
					end
				end
				MO_EXIT: begin
					trec_q.life <= LIFE_ZOMB;
					trec_q.ticks <= sat32(trec_q.ticks);
					zomb_q <= sat32(zomb_q);
					outcome_q <= OUT_DONE;
				end
				MO_SIG: begin
					priority if (arg_q == SIG_STOP &&
						(trec_q.life == LIFE_RUN || trec_q.life == LIFE_BLK)) begin
						trec_q.life <= LIFE_STOP;
						trec_q.ticks <= sat32(trec_q.ticks);
						outcome_q <= OUT_DONE;
					end else if (arg_q == SIG_CONT && trec_q.life == LIFE_STOP) begin
						trec_q.life <= LIFE_RUN;
						trec_q.ticks <= sat32(trec_q.ticks);
						outcome_q <= OUT_DONE;
					end else if (arg_q == SIG_TERM && trec_q.life != LIFE_ZOMB) begin
						trec_q.life <= LIFE_ZOMB;
						trec_q.ticks <= sat32(trec_q.ticks);
						killed_q <= sat32(killed_q);
						outcome_q <= OUT_DONE;
					end else begin
						outcome_q <= OUT_NONE;
					end
				end
				MO_NICE: begin
					priority if (nsum < 0) trec_q.pri <= 2'd0;
					else if (nsum > 18'sd3) trec_q.pri <= PRI_MAX;
					else trec_q.pri <= nsum[1:0];
					trec_q.ticks <= sat32(trec_q.ticks);
					outcome_q <= OUT_DONE;
				end
				MO_CHK: if (c_live) live_q <= 1'b1;
				MO_KILL: begin
					killed_q <= sat32(killed_q);
					outcome_q <= OUT_DONE;
				end
				MO_NEXT: k_q <= k_q + CNT_W'(1);
				MO_REAP: begin
					if (active_q != 7'd0) active_q <= active_q - 7'd1;
					pid_out_q <= slot_rd.pid;
					trec_q.life <= LIFE_RUN;
					trec_q.ticks <= sat32(trec_q.ticks);
					outcome_q <= OUT_DONE;
				end
				MO_LMOVE: trec_q.cnt <= lastk;
				MO_WFIN: begin
					priority if (live_q) begin
						trec_q.life <= LIFE_BLK;
						outcome_q <= OUT_BLOCKED;
					end else if (trec_q.life == LIFE_BLK) begin
						trec_q.life <= LIFE_RUN;
						outcome_q <= OUT_DONE;
					end else begin
						outcome_q <= OUT_NONE;
					end
				end
				MO_OUT: begin
					out_valid_q <= 1'b1;
					out_data_q <= {1'b0, killed_q, zomb_q, active_q, peak_q, created_q,
						tfound_q ? trec_q.ticks : 32'd0,
						tfound_q ? trec_q.pri : 2'd0,
						tfound_q ? trec_q.life : LIFE_TERM,
						tfound_q, pid_out_q, outcome_q};
				end
				default: ;
			endcase
		end
	end

	// status toward the controller
	always_comb begin
		st.op = op_q;
		st.tfound = tfound_q;
		st.ffound = ffound_q;
		st.nopid = next_pid_q[16];
		st.t_zombie = trec_q.life == LIFE_ZOMB;
		st.tidx_zero = tidx_q == '0;
		st.scan_last = k_q == CNT_W'(SLOTS - 1);
		st.loop_end = k_q == trec_q.cnt;
		st.c_live = c_live;
		st.c_zombie = slot_rd.life == LIFE_ZOMB;
		st.c_match = c_live && slot_rd.life == LIFE_ZOMB &&
			(arg_q == ANY_CHILD || slot_rd.pid == arg_q);
		st.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	`PTLE_ASSERT(a_peak_ge_active, peak_q >= active_q, "peak below active count")
	`PTLE_ASSERT(a_created_tracks_pid, created_q == 32'(next_pid_q) - 32'd1, "created count off")
	`PTLE_ASSERT_NEXT(a_fork_pid_step, mo == MO_FORK, next_pid_q == $past(next_pid_q) + 17'd1, "pid stuck")
endmodule
`default_nettype wire

// File: src/ptle_ctrl.sv
`default_nettype none
module ptle_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire ptle_pkg::dp_status_t st,
	output logic                      in_ready,
	output ptle_pkg::mo_t             mo
);
	import ptle_pkg::*;
	`include "process_table_lifecycle_engine_defines.svh"

	typedef enum logic [21:0] {
		ST_IDLE  = 22'h000001,
		ST_SCAN  = 22'h000002,
		ST_SFIN  = 22'h000004,
		ST_DISP  = 22'h000008,
		ST_FORK  = 22'h000010,
		ST_EXIT  = 22'h000020,
		ST_SIG   = 22'h000040,
		ST_NICE  = 22'h000080,
		ST_WBT   = 22'h000100,
		ST_LOOP  = 22'h000200,
		ST_LRD   = 22'h000400,
		ST_CRD   = 22'h000800,
		ST_CHK   = 22'h001000,
		ST_IRD   = 22'h002000,
		ST_IADD  = 22'h004000,
		ST_KILL  = 22'h008000,
		ST_NEXT  = 22'h010000,
		ST_REAP  = 22'h020000,
		ST_LLAST = 22'h040000,
		ST_LMOVE = 22'h080000,
		ST_WFIN  = 22'h100000,
		ST_OUT   = 22'h200000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = state_q == ST_IDLE;

	// next state and micro-operation
	always_comb begin
		state_d = state_q;
		mo = MO_IDLE;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				mo = MO_LOAD;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				mo = MO_SCAN;
				if (st.scan_last) state_d = ST_SFIN;
			end
			ST_SFIN: state_d = ST_DISP;
			ST_DISP: begin
				mo = MO_DISP;
				unique case (st.op)
					OP_FORK: state_d = (st.ffound && !st.nopid) ? ST_FORK : ST_OUT;
					OP_EXIT: state_d = (st.tfound && !st.t_zombie) ? ST_EXIT : ST_OUT;
					OP_WAIT, OP_KILLALL: state_d = st.tfound ? ST_LOOP : ST_OUT;
					OP_SIGNAL: state_d = st.tfound ? ST_SIG : ST_OUT;
					OP_NICE: state_d = st.tfound ? ST_NICE : ST_OUT;
					default: state_d = ST_OUT;
				endcase
			end
			ST_FORK: begin
				mo = MO_FORK;
				state_d = ST_WBT;
			end
			ST_EXIT: begin
				mo = MO_EXIT;
				state_d = ST_WBT;
			end
			ST_SIG: begin
				mo = MO_SIG;
				state_d = ST_WBT;
			end
			ST_NICE: begin
				mo = MO_NICE;
				state_d = ST_WBT;
			end
			ST_WBT: begin
				mo = MO_WBT;
				state_d = (st.op == OP_EXIT) ? ST_LOOP : ST_OUT;
			end
			// walk of the target's child list
			ST_LOOP: begin
				priority if (!st.loop_end) state_d = ST_LRD;
				else if (st.op == OP_WAIT) state_d = ST_WFIN;
				else state_d = ST_OUT;
			end
			ST_LRD: begin
				mo = MO_LRD;
				state_d = ST_CRD;
			end
			ST_CRD: begin
				mo = MO_CRD;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				mo = MO_CHK;
				priority if (st.op == OP_EXIT)
					state_d = (st.c_live && !st.tidx_zero) ? ST_IRD : ST_NEXT;
				else if (st.op == OP_KILLALL)
					state_d = (st.c_live && !st.c_zombie) ? ST_KILL : ST_NEXT;
				else
					state_d = st.c_match ? ST_REAP : ST_NEXT;
			end
			ST_IRD: begin
				mo = MO_IRD;
				state_d = ST_IADD;
			end
			ST_IADD: begin
				mo = MO_IADD;
				state_d = ST_NEXT;
			end
			ST_KILL: begin
				mo = MO_KILL;
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				mo = MO_NEXT;
				state_d = ST_LOOP;
			end
			ST_REAP: begin
				mo = MO_REAP;
				state_d = ST_LLAST;
			end
			ST_LLAST: begin
				mo = MO_LLAST;
				state_d = ST_LMOVE;
			end
			ST_LMOVE: begin
				mo = MO_LMOVE;
				state_d = ST_WBT;
			end
			ST_WFIN: begin
				mo = MO_WFIN;
				state_d = ST_WBT;
			end
			ST_OUT: if (st.out_free) begin
				mo = MO_OUT;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`PTLE_ASSERT(a_fork_has_room, (state_q == ST_FORK) |-> (st.ffound && !st.nopid), "fork no room")
	`PTLE_ASSERT(a_state_onehot, $onehot(state_q), "state not one-hot")
	`PTLE_ASSERT_NEXT(a_accept_scan, in_valid && in_ready, state_q == ST_SCAN, "accept without sweep")
endmodule
`default_nettype wire

// File: tb/process_table_lifecycle_engine_checker.sv
`default_nettype none
module process_table_lifecycle_engine_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	// operation[2:0], target_pid[18:3], argument[34:19], zero pad
	input  wire logic [39:0]  s_axis_tdata,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// outcome[2:0], pid_out[18:3], entry_found[19], entry_state[22:20],
	// entry_priority[24:23], entry_ticks[56:25], created_total[88:57],
	// peak_active[95:89], active_now[102:96], zombies_total[134:103],
	// killed_total[166:135], zero pad
	input  wire logic [167:0] m_axis_tdata,
	output int                errors,
	output int                pending
);
	import ptle_pkg::*;

	// mirror of the process table
	logic [15:0] t_pid [SLOTS];
	logic [15:0] t_parent [SLOTS];
	logic [2:0]  t_life [SLOTS];
	logic [1:0]  t_pri [SLOTS];
	logic [31:0] t_ticks [SLOTS];
	int          t_nkids [SLOTS];
	logic [15:0] t_kids [SLOTS][SLOTS];
	int          pid_next;
	logic [31:0] n_created, n_zomb, n_killed;
	logic [6:0]  n_peak, n_active;

	logic [167:0] expected_results[$];

	assign pending = expected_results.size();

	function automatic int lookup(input logic [15:0] pid);
		for (int i = 0; i < SLOTS; i++)
			if (t_pid[i] == pid && t_life[i] != LIFE_TERM) return i;
		return -1;
	endfunction

	function automatic void add_kid(input int o, input logic [15:0] pid);
		if (t_nkids[o] < SLOTS) begin
			t_kids[o][t_nkids[o]] = pid;
			t_nkids[o]++;
		end
	endfunction

	function automatic void kill_to_zombie(input int i);
		t_life[i] = LIFE_ZOMB;
		t_ticks[i] = sat32(t_ticks[i]);
	endfunction

	function automatic void clear_table();
		for (int i = 0; i < SLOTS; i++) begin
			t_pid[i] = '0; t_parent[i] = '0; t_life[i] = LIFE_TERM;
			t_pri[i] = 2'd1; t_ticks[i] = '0; t_nkids[i] = 0;
		end
		t_pid[0] = INIT_PID; t_life[0] = LIFE_RUN; t_pri[0] = 2'd0;
		pid_next = 2; n_created = 32'd1; n_peak = 7'd1; n_active = 7'd1;
		n_zomb = '0; n_killed = '0;
	endfunction

	// apply one command to the mirror and build the result word
	function automatic logic [167:0] apply_command(input logic [39:0] d);
		logic [2:0]  op, outc;
		logic [15:0] tgt, arg, pout;
		int p, c, n, fs, ii, np;
		logic hit, live;
		logic [167:0] r;
		op = d[2:0]; tgt = d[18:3]; arg = d[34:19];
		outc = OUT_NONE; pout = '0;
		p = lookup(tgt);
		case (op)
			OP_FORK: begin
				fs = -1;
				for (int i = SLOTS - 1; i >= 0; i--) if (t_life[i] == LIFE_TERM) fs = i;
				if (fs < 0) outc = OUT_FULL;
				else if (pid_next > 65535) outc = OUT_NOPID;
				else begin
					t_pid[fs] = pid_next[15:0]; t_parent[fs] = tgt; t_life[fs] = LIFE_RUN;
					t_nkids[fs] = 0; t_ticks[fs] = '0;
					t_pri[fs] = (p >= 0) ? t_pri[p] : 2'd1;
					if (p >= 0) begin
						t_ticks[p] = sat32(t_ticks[p]);
						add_kid(p, pid_next[15:0]);
					end
					pout = pid_next[15:0]; pid_next++;
					n_created = sat32(n_created);
					if (n_active < ACT_MAX) n_active++;
					if (n_active > n_peak) n_peak = n_active;
					outc = OUT_DONE;
				end
			end
			OP_EXIT: if (p >= 0 && t_life[p] != LIFE_ZOMB) begin
				kill_to_zombie(p);
				ii = lookup(INIT_PID);
				n = t_nkids[p];
				for (int k = 0; k < n; k++) begin
					c = lookup(t_kids[p][k]);
					if (c >= 0) begin
						t_parent[c] = INIT_PID;
						if (ii >= 0 && ii != p) add_kid(ii, t_kids[p][k]);
					end
				end
				n_zomb = sat32(n_zomb);
				outc = OUT_DONE;
			end
			OP_WAIT: if (p >= 0) begin
				live = 1'b0;
				for (int k = 0; k < t_nkids[p]; k++)
					if (lookup(t_kids[p][k]) >= 0) live = 1'b1;
				if (!live) begin
					if (t_life[p] == LIFE_BLK) begin
						t_life[p] = LIFE_RUN; outc = OUT_DONE;
					end
				end else begin
					hit = 1'b0; n = t_nkids[p];
					for (int k = 0; k < n && !hit; k++) begin
						c = lookup(t_kids[p][k]);
						if (c >= 0 && t_life[c] == LIFE_ZOMB &&
								(arg == ANY_CHILD || t_pid[c] == arg)) begin
							hit = 1'b1; pout = t_pid[c];
							t_life[c] = LIFE_TERM;
							if (n_active > 0) n_active--;
							for (int j = 0; j < n; j++)
								if (t_kids[p][j] == pout) begin
									t_kids[p][j] = t_kids[p][n - 1];
									t_nkids[p] = n - 1;
									break;
								end
							t_life[p] = LIFE_RUN;
							t_ticks[p] = sat32(t_ticks[p]);
							outc = OUT_DONE;
						end
					end
					if (!hit) begin
						t_life[p] = LIFE_BLK; outc = OUT_BLOCKED;
					end
				end
			end
			OP_KILLALL: if (p >= 0) begin
				for (int k = 0; k < t_nkids[p]; k++) begin
					c = lookup(t_kids[p][k]);
					if (c >= 0 && t_life[c] != LIFE_ZOMB) begin
						kill_to_zombie(c);
						n_killed = sat32(n_killed);
						outc = OUT_DONE;
					end
				end
			end
			OP_SIGNAL: if (p >= 0) begin
				if (arg == SIG_STOP && (t_life[p] == LIFE_RUN || t_life[p] == LIFE_BLK)) begin
					t_life[p] = LIFE_STOP; t_ticks[p] = sat32(t_ticks[p]); outc = OUT_DONE;
				end else if (arg == SIG_CONT && t_life[p] == LIFE_STOP) begin
					t_life[p] = LIFE_RUN; t_ticks[p] = sat32(t_ticks[p]); outc = OUT_DONE;
				end else if (arg == SIG_TERM && t_life[p] != LIFE_ZOMB) begin
					kill_to_zombie(p); n_killed = sat32(n_killed); outc = OUT_DONE;
				end
			end
			OP_NICE: if (p >= 0) begin
				np = int'(t_pri[p]) + int'($signed(arg));
				if (np < 0) np = 0;
				if (np > 3) np = 3;
				t_pri[p] = np[1:0];
				t_ticks[p] = sat32(t_ticks[p]);
				outc = OUT_DONE;
			end
			default: outc = OUT_NONE;
		endcase
		p = lookup(tgt);
		r = '0;
		r[2:0] = outc; r[18:3] = pout;
		r[19] = (p >= 0);
		r[22:20] = (p >= 0) ? t_life[p] : LIFE_TERM;
		r[24:23] = (p >= 0) ? t_pri[p] : 2'd0;
		r[56:25] = (p >= 0) ? t_ticks[p] : 32'd0;
		r[88:57] = n_created; r[95:89] = n_peak; r[102:96] = n_active;
		r[134:103] = n_zomb; r[166:135] = n_killed;
		return r;
	endfunction

	// predict on each accepted command, compare each accepted result
	always @(posedge clk or negedge arst_n) begin
		logic [167:0] e;
		if (!arst_n) begin
			clear_table();
			expected_results.delete();
			errors <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(apply_command(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_axis_tdata);
					errors <= errors + 1;
				end else begin
					e = expected_results.pop_front();
					if (e !== m_axis_tdata) begin
						$display("%0t: mismatch expected %h actual %h", $time, e, m_axis_tdata);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: tb/process_table_lifecycle_engine_tb.sv
`default_nettype none
module process_table_lifecycle_engine_tb;
	import ptle_pkg::*;

	logic         clk, arst_n;
	logic         s_axis_tvalid, s_axis_tready;
	logic [39:0]  s_axis_tdata;
	logic         m_axis_tvalid, m_axis_tready;
	logic [167:0] m_axis_tdata;
	int           errors, pending;
	int           hold_cycles;

	process_table_lifecycle_engine uut (.*);
	process_table_lifecycle_engine_checker chk (.*);

	// track pids handed out so random commands name real processes
	logic [15:0] known_pids[$];

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// one command: random gap, then hold until accepted
	task automatic send_command(input logic [2:0] op, input logic [15:0] tgt,
			input logic [15:0] arg);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
		// valid drops only when an idle gap follows
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, arg, tgt, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_pid();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 16'($urandom);
		if (r < 4 || known_pids.size() == 0) return INIT_PID;
		return known_pids[$urandom_range(0, known_pids.size() - 1)];
	endfunction

	function automatic logic [15:0] pick_signal();
		case ($urandom_range(0, 4))
			0: return SIG_STOP;
			1: return SIG_CONT;
			2: return SIG_TERM;
			3: return 16'($urandom_range(0, 31));
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver: random stall per item, one long hold-off early on
	initial begin
		int wait_n;
		m_axis_tready = 0;
		hold_cycles = 0;
		@(posedge arst_n);
		repeat (30) @(posedge clk);
		hold_cycles = 2000;
		repeat (hold_cycles) @(posedge clk);
		forever begin
			wait_n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
			if (wait_n != 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin
		logic [15:0] p;
		int r, guard;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: field extremes, each operation, unknown codes
		send_command(OP_FORK, INIT_PID, 16'h0000);
		send_command(OP_FORK, 16'd2, 16'hFFFF);
		send_command(OP_FORK, 16'hFFFF, 16'h8000);
		send_command(OP_NICE, 16'd2, 16'h7FFF);
		send_command(OP_NICE, 16'd2, 16'h8000);
		send_command(OP_NICE, 16'd3, 16'd1);
		send_command(OP_WAIT, INIT_PID, ANY_CHILD);
		send_command(OP_SIGNAL, 16'd3, SIG_STOP);
		send_command(OP_SIGNAL, 16'd3, SIG_STOP);
		send_command(OP_SIGNAL, 16'd3, SIG_CONT);
		send_command(OP_SIGNAL, 16'd2, 16'd9);
		send_command(OP_EXIT, 16'd2, 16'hFFFF);
		send_command(OP_EXIT, 16'd2, 16'd0);
		send_command(OP_WAIT, INIT_PID, 16'd3);
		send_command(OP_WAIT, INIT_PID, 16'd2);
		send_command(OP_WAIT, INIT_PID, ANY_CHILD);
		send_command(OP_KILLALL, INIT_PID, 16'd0);
		send_command(OP_KILLALL, INIT_PID, 16'd0);
		send_command(OP_WAIT, INIT_PID, ANY_CHILD);
		send_command(OP_WAIT, 16'd4, ANY_CHILD);
		send_command(OP_SIGNAL, 16'd4, SIG_TERM);
		send_command(3'd6, 16'h0000, 16'h1234);
		send_command(3'd7, INIT_PID, 16'hEDCB);
		// random: mostly valid pids, fork-heavy so the table fills
		for (int n = 0; n < 1100; n++) begin
			r = $urandom_range(0, 99);
			p = pick_pid();
			if (r < 30) begin
				send_command(OP_FORK, p, 16'($urandom));
				if (chk.pid_next <= 65535) known_pids.push_back(chk.pid_next[15:0] - 16'd1);
				if (known_pids.size() > 80) void'(known_pids.pop_front());
			end else if (r < 42) send_command(OP_EXIT, p, 16'($urandom));
			else if (r < 65) send_command(OP_WAIT, p,
					$urandom_range(0, 1) ? ANY_CHILD : pick_pid());
			else if (r < 72) send_command(OP_KILLALL, p, 16'($urandom));
			else if (r < 88) send_command(OP_SIGNAL, p, pick_signal());
			else if (r < 97) send_command(OP_NICE, p,
					$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6) - 3));
			else send_command(3'($urandom_range(6, 7)), 16'($urandom), 16'($urandom));
		end
		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (pending != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (500) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
